@@ hw/rtl/tks_pkg.sv @@
// Shared types, constants and the exponent table of the top-k sampler.
package tks_pkg;

  localparam int VOCAB_DEPTH = 4096;
  localparam int MAX_TOP     = 64;
  localparam int VOCAB_AW    = $clog2(VOCAB_DEPTH);
  localparam int CNT_W       = $clog2(VOCAB_DEPTH + 1);
  localparam int TOP_AW      = $clog2(MAX_TOP);
  localparam int K_W         = $clog2(MAX_TOP + 1);
  localparam int IDX_W       = 12;
  localparam int TEMP_W      = 16;
  localparam int TOPC_W      = 7;
  localparam int WGT_W       = 17;
  localparam int TOTAL_W     = WGT_W + TOP_AW;
  localparam int DIVD_W      = 41;
  localparam int RT_W        = 31 + TOTAL_W;

  localparam logic [31:0] RNG_RESET  = 32'hDEADBEEF;
  localparam logic [30:0] RAND_MASK  = 31'h7FFFFFFF;
  localparam logic [16:0] LOG2E_Q16  = 17'd94548;
  localparam logic [31:0] EXP_STEP   = 32'd4283353945;
  localparam logic [TEMP_W-1:0] TEMP_RESET = 16'd205;
  localparam logic [TOPC_W-1:0] TOPC_RESET = 7'd8;

  // register indexes on the configuration port
  localparam logic [1:0] REG_TEMPERATURE = 2'd0;
  localparam logic [1:0] REG_TOP_COUNT   = 2'd1;
  localparam logic [1:0] REG_RNG_SEED    = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_SETUP, S_PASS_ORD, S_PASS_SC, S_PASS_CUR, S_J_ORD, S_J_SC, S_J_CMP,
    S_PASS_END, S_W_RD, S_W_DIV, S_W_WAIT, S_W_MUL, S_W_LUT, S_D_RNG, S_D_MUL,
    S_D_RD, S_D_CMP, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_SETUP, OP_PASS_ORD, OP_PASS_SC, OP_PASS_CUR, OP_J_ORD, OP_J_SC,
    OP_J_CMP, OP_PASS_END, OP_W_RD, OP_W_DIV, OP_W_MUL, OP_W_LUT, OP_D_RNG,
    OP_D_MUL, OP_D_RD, OP_D_CMP
  } op_t;

  typedef struct packed {
    logic j_end;
    logic j_last;
    logic i_last;
    logic w_last;
    logic div_done;
    logic hit;
  } status_t;

  typedef logic [WGT_W-1:0] exp_tab_t [256];

  // 2^(-i/256) in Q1.16, built by repeated Q0.32 multiplication
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    t;
    logic [63:0] acc;
    acc = 64'h1_0000_0000;
    for (int i = 0; i < 256; i++) begin
      t[i] = WGT_W'((acc + 64'h8000) >> 16);
      acc  = (acc * 64'(EXP_STEP) + 64'h8000_0000) >> 32;
    end
    return t;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

@@ hw/rtl/tks_div.sv @@
// Restoring divider, one quotient bit per cycle.
module tks_div
  import tks_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [TEMP_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quot
);

  logic [TEMP_W-1:0]          rem;
  logic [TEMP_W-1:0]          dsr;
  logic [$clog2(DIVD_W+1)-1:0] cnt;
  logic                       running;
  logic [TEMP_W:0]            rem_sh;
  logic                       fits;

  assign rem_sh = {rem, quot[DIVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr};

  // control: count the bits down
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= ($clog2(DIVD_W+1))'(DIVD_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == 1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath: shift, trial subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dsr  <= divisor;
      quot <= dividend;
    end else if (running) begin
      rem  <= fits ? TEMP_W'(rem_sh - {1'b0, dsr}) : TEMP_W'(rem_sh);
      quot <= {quot[DIVD_W-2:0], fits};
    end
  end

endmodule

@@ hw/rtl/tks_dpath.sv @@
// Datapath: score, order, candidate and weight stores, counters, weights and draw.
module tks_dpath
  import tks_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  op_t               op,
  input  logic              accept,
  input  logic [31:0]       logit_value,
  input  logic              last_logit,
  input  logic [TEMP_W-1:0] temperature,
  input  logic [TOPC_W-1:0] top_count,
  input  logic              seed_load,
  input  logic [31:0]       seed_value,
  output status_t           status,
  output logic [IDX_W-1:0]  token_index
);

  logic [31:0]         score_mem [VOCAB_DEPTH];
  logic [VOCAB_AW-1:0] order_mem [VOCAB_DEPTH];
  logic [VOCAB_AW+31:0] ent_mem  [MAX_TOP];
  logic [WGT_W-1:0]    wgt_mem   [MAX_TOP];

  logic [CNT_W-1:0]    load_count, n_run, j_cnt;
  logic [K_W-1:0]      k_run;
  logic [TOP_AW-1:0]   i_cnt, w_cnt;
  logic [VOCAB_AW-1:0] cur_idx, cand, best_idx;
  logic [31:0]         cur_score, best_score;
  logic [31:0]         sc_q;
  logic [VOCAB_AW-1:0] ord_q;
  logic [VOCAB_AW+31:0] ent_q;
  logic [WGT_W-1:0]    wgt_q;
  logic [21:0]         y_reg;
  logic                big_reg;
  logic [TOTAL_W-1:0]  total, cum;
  logic [30:0]         rnd;
  logic [RT_W-1:0]     rt;
  logic [31:0]         rng_word;

  logic                first;
  logic [VOCAB_AW-1:0] sc_raddr, ord_raddr, pick;
  logic                gt;
  logic [TOTAL_W-1:0]  cum_next;
  logic [RT_W-1:0]     cum_scaled;
  logic [32:0]         diff;
  logic [DIVD_W-1:0]   quot;
  logic                div_done;
  logic [TEMP_W-1:0]   temp_eff;
  logic [K_W-1:0]      lim;
  logic [5:0]          ip;
  logic [WGT_W-1:0]    wgt;
  logic [31:0]         x1, x2, x3;

  assign first    = (i_cnt == '0);
  assign pick     = first ? ((op == OP_PASS_SC) ? '0 : j_cnt[VOCAB_AW-1:0]) : ord_q;
  assign sc_raddr = pick;
  assign ord_raddr = (op == OP_PASS_ORD) ? VOCAB_AW'(i_cnt) : j_cnt[VOCAB_AW-1:0];
  assign gt       = $signed(sc_q) > $signed(cur_score);
  assign temp_eff = (temperature == '0) ? TEMP_W'(1) : temperature;
  assign diff     = {best_score[31], best_score} - {ent_q[31], ent_q[31:0]};
  assign cum_next = cum + TOTAL_W'(wgt_q);
  assign cum_scaled = {cum_next, 31'b0} - RT_W'(cum_next);
  assign ip       = y_reg[21:16];
  assign wgt      = (big_reg || ip > 6'd16) ? '0 : (EXP_TAB[y_reg[15:8]] >> ip[4:0]);
  assign x1       = rng_word ^ (rng_word << 13);
  assign x2       = x1 ^ (x1 >> 17);
  assign x3       = x2 ^ (x2 << 5);

  // clamp top count into 1..MAX_TOP
  always_comb begin
    lim = (top_count == '0) ? K_W'(1) : K_W'(top_count);
    if (lim > K_W'(MAX_TOP)) lim = K_W'(MAX_TOP);
  end

  assign status.j_end    = (CNT_W'(i_cnt) + 1'b1) == n_run;
  assign status.j_last   = (j_cnt + 1'b1) == n_run;
  assign status.i_last   = (K_W'(i_cnt) + 1'b1) == k_run;
  assign status.w_last   = (K_W'(w_cnt) + 1'b1) == k_run;
  assign status.div_done = div_done;
  assign status.hit      = cum_scaled >= rt;

  tks_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (op == OP_W_DIV),
    .dividend ({diff, 8'b0}),
    .divisor  (temp_eff),
    .done     (div_done),
    .quot     (quot)
  );

  // score store: load port and one registered read
  always_ff @(posedge clk) begin
    if (accept && !load_count[CNT_W-1]) score_mem[load_count[VOCAB_AW-1:0]] <= logit_value;
    sc_q <= score_mem[sc_raddr];
  end

  // order store: swap write-back and one registered read
  always_ff @(posedge clk) begin
    if (op == OP_J_CMP && (gt || first))
      order_mem[j_cnt[VOCAB_AW-1:0]] <= gt ? cur_idx : cand;
    else if (op == OP_PASS_END)
      order_mem[VOCAB_AW'(i_cnt)] <= cur_idx;
    ord_q <= order_mem[ord_raddr];
  end

  // candidate and weight stores
  always_ff @(posedge clk) begin
    if (op == OP_PASS_END) ent_mem[i_cnt] <= {cur_idx, cur_score};
    if (op == OP_W_LUT) wgt_mem[w_cnt] <= wgt;
    ent_q <= ent_mem[w_cnt];
    wgt_q <= wgt_mem[w_cnt];
  end

  // load counter and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      rng_word   <= RNG_RESET;
    end else begin
      if (accept) begin
        if (last_logit) load_count <= '0;
        else if (!load_count[CNT_W-1]) load_count <= load_count + 1'b1;
      end
      if (seed_load) rng_word <= seed_value;
      else if (op == OP_D_RNG) rng_word <= x3;
    end
  end

  // run registers, advanced by the controller's command
  always_ff @(posedge clk) begin
    if (accept && last_logit)
      n_run <= load_count + CNT_W'(!load_count[CNT_W-1]);
    unique case (op)
      OP_SETUP: begin
        k_run <= (CNT_W'(lim) > n_run) ? K_W'(n_run) : lim;
        i_cnt <= '0;
        w_cnt <= '0;
        total <= '0;
      end
      OP_PASS_ORD: j_cnt <= CNT_W'(i_cnt) + 1'b1;
      OP_PASS_SC:  cur_idx <= pick;
      OP_PASS_CUR: cur_score <= sc_q;
      OP_J_SC:     cand <= pick;
      OP_J_CMP: begin
        if (gt) begin
          cur_idx   <= cand;
          cur_score <= sc_q;
        end
        j_cnt <= j_cnt + 1'b1;
      end
      OP_PASS_END: begin
        if (first) begin
          best_idx   <= cur_idx;
          best_score <= cur_score;
        end
        i_cnt <= i_cnt + 1'b1;
      end
      OP_W_MUL: begin
        big_reg <= (|quot[DIVD_W-1:21]) || (quot[20:0] > 21'h100000);
        y_reg   <= 22'((38'(quot[20:0]) * 38'(LOG2E_Q16)) >> 16);
      end
      OP_W_LUT: begin
        total <= total + TOTAL_W'(wgt);
        w_cnt <= w_cnt + 1'b1;
      end
      OP_D_RNG: begin
        rnd   <= x3[30:0] & RAND_MASK;
        w_cnt <= '0;
        cum   <= '0;
      end
      OP_D_MUL: rt <= RT_W'(rnd) * RT_W'(total);
      OP_D_CMP: begin
        cum   <= cum_next;
        w_cnt <= w_cnt + 1'b1;
        if (status.hit) token_index <= IDX_W'(ent_q[VOCAB_AW+31:32]);
        else if (status.w_last) token_index <= IDX_W'(best_idx);
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/tks_ctrl.sv @@
// Controller: sequences selection passes, weighting and the draw.
module tks_ctrl
  import tks_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  logic    last_logit,
  input  status_t status,
  output op_t     op,
  output logic    busy,
  output logic    done
);

  state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (accept && last_logit) state_next = S_SETUP;
      S_SETUP:    state_next = S_PASS_ORD;
      S_PASS_ORD: state_next = S_PASS_SC;
      S_PASS_SC:  state_next = S_PASS_CUR;
      S_PASS_CUR: state_next = status.j_end ? S_PASS_END : S_J_ORD;
      S_J_ORD:    state_next = S_J_SC;
      S_J_SC:     state_next = S_J_CMP;
      S_J_CMP:    state_next = status.j_last ? S_PASS_END : S_J_ORD;
      S_PASS_END: state_next = status.i_last ? S_W_RD : S_PASS_ORD;
      S_W_RD:     state_next = S_W_DIV;
      S_W_DIV:    state_next = S_W_WAIT;
      S_W_WAIT:   if (status.div_done) state_next = S_W_MUL;
      S_W_MUL:    state_next = S_W_LUT;
      S_W_LUT:    state_next = status.w_last ? S_D_RNG : S_W_RD;
      S_D_RNG:    state_next = S_D_MUL;
      S_D_MUL:    state_next = S_D_RD;
      S_D_RD:     state_next = S_D_CMP;
      S_D_CMP:    state_next = (status.hit || status.w_last) ? S_DONE : S_D_RD;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy = (state != S_IDLE);
    done = (state == S_DONE);
    unique case (state)
      S_SETUP:    op = OP_SETUP;
      S_PASS_ORD: op = OP_PASS_ORD;
      S_PASS_SC:  op = OP_PASS_SC;
      S_PASS_CUR: op = OP_PASS_CUR;
      S_J_ORD:    op = OP_J_ORD;
      S_J_SC:     op = OP_J_SC;
      S_J_CMP:    op = OP_J_CMP;
      S_PASS_END: op = OP_PASS_END;
      S_W_RD:     op = OP_W_RD;
      S_W_DIV:    op = OP_W_DIV;
      S_W_MUL:    op = OP_W_MUL;
      S_W_LUT:    op = OP_W_LUT;
      S_D_RNG:    op = OP_D_RNG;
      S_D_MUL:    op = OP_D_MUL;
      S_D_RD:     op = OP_D_RD;
      S_D_CMP:    op = OP_D_CMP;
      default:    op = OP_NONE;
    endcase
  end

endmodule

@@ hw/rtl/top_k_temperature_sampler_top.sv @@
// Top level of the top-k temperature sampler: register port, controller, datapath.
// Loading: one score per cycle while busy is low; a beat without last_logit leaves busy low.
// Run after the last score: k selection passes over the scores not yet taken, then one divide
// and table lookup per candidate for its weight, then a draw that walks the candidates.
// done strobes token_index for one cycle at the end of the run; the receiver cannot stall.
// rst (synchronous) clears the load count, state, registers and reloads the generator.
module top_k_temperature_sampler_top
  import tks_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [31:0]       logit_value,
  input  logic              last_logit,
  output logic              done,
  output logic [IDX_W-1:0]  token_index,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [TEMP_W-1:0] temperature;
  logic [TOPC_W-1:0] top_count;
  logic [31:0]       rng_seed;
  logic              wr, accept, seed_load;
  op_t               op;
  status_t           status;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign accept    = start && !busy;
  assign seed_load = wr && (paddr[3:2] == REG_RNG_SEED);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      temperature <= TEMP_RESET;
      top_count   <= TOPC_RESET;
      rng_seed    <= RNG_RESET;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_TEMPERATURE: temperature <= pwdata[TEMP_W-1:0];
        REG_TOP_COUNT:   top_count   <= pwdata[TOPC_W-1:0];
        REG_RNG_SEED:    rng_seed    <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      REG_TEMPERATURE: prdata = 32'(temperature);
      REG_TOP_COUNT:   prdata = 32'(top_count);
      REG_RNG_SEED:    prdata = rng_seed;
      default:         prdata = '0;
    endcase
  end

  tks_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .last_logit (last_logit),
    .status     (status),
    .op         (op),
    .busy       (busy),
    .done       (done)
  );

  tks_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .accept      (accept),
    .logit_value (logit_value),
    .last_logit  (last_logit),
    .temperature (temperature),
    .top_count   (top_count),
    .seed_load   (seed_load),
    .seed_value  (pwdata),
    .status      (status),
    .token_index (token_index)
  );

endmodule

@@ hw/rtl/tks_checker.sv @@
// Port-level checks of the sampler, bound to the top level.
module tks_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last_logit,
  input logic done
);

  // a result beat only comes out of a run
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // the last score starts a run
  a_last_runs: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_logit) |=> busy)
    else $error("last beat did not start a run");

  // other scores leave the block ready
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last_logit) |=> !busy && !done)
    else $error("plain score made the block busy");

  // the run ends with its result beat
  a_done_ends: assert property (@(posedge clk) disable iff (rst) done |=> !busy && !done)
    else $error("run did not end after result");

endmodule

bind top_k_temperature_sampler_top tks_checker u_tks_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .last_logit (last_logit),
  .done       (done)
);
